### sv/acs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the alarm clock set controller.
// Used by the front end, the request queue and the back end; depends on nothing.
package acs_pkg;

  // Bit positions of the pending button mask.
  localparam int BTN_PLUS   = 0;
  localparam int BTN_MINUS  = 1;
  localparam int BTN_SET    = 2;
  localparam int BTN_SNOOZE = 3;

  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [5:0] MIN_LAST    = 6'd59;
  localparam logic [4:0] HRS_LAST_24 = 5'd23;
  localparam logic [4:0] HRS_LAST_12 = 5'd12;
  localparam logic [4:0] HRS_PM_EDGE = 5'd11;
  localparam logic [4:0] HRS_FIRST_12 = 5'd1;

  // One request as classified by the front end.
  typedef struct packed {
    logic [3:0] buttons;
    logic       blink;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic       sec_even;
    logic       pm;
  } item_t;

  // One display and RTC-write result.
  typedef struct packed {
    logic [3:0] digit_hours_tens;
    logic [3:0] digit_hours_units;
    logic [3:0] digit_minutes_tens;
    logic [3:0] digit_minutes_units;
    logic       colon_lit;
    logic       alarm_indicator;
    logic       pm_indicator;
    logic       alarm_armed;
    logic       time_write;
    logic [4:0] write_hours;
    logic [5:0] write_minutes;
    logic       write_pm;
  } result_t;

  // Tens digit of a value below 64, by multiplying with 13/128.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = {4'd0, v} * 10'd13;
    return p[9:7];
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] u;
    u = v - ({3'd0, tens_of(v)} * 6'd10);
    return u[3:0];
  endfunction

endpackage

### sv/alarm_clock_set_controller.sv
`timescale 1ns / 1ps
// Alarm clock set controller.
// Input channel: in_valid / in_stall carry one request per step: button press
// pulses, the blink phase and an RTC time snapshot. Output channel:
// out_valid / out_stall carry one result per request: four decimal display
// digits (10 is blank), colon, alarm and PM indicators, the alarm enable level
// and a one-result RTC write strobe with the time to write.
// cfg_write_en / cfg_write_data set the 12 or 24 hour format; write it only
// while no request is in flight.
// A request accepted into the two-entry queue is popped from it and its result
// registered in the back end's output register, which raises out_valid; a
// receiver stall can hold it in the queue. One request per cycle is sustained
// while out_stall is low; each is one step of the back end's mode state machine.
// When the receiver stalls, the result register holds and the queue absorbs
// up to two more requests before in_stall rises.
// Reset (rst, synchronous) empties the queue, drops out_valid, selects 12 hour
// format and returns the mode machine to its start step with no alarm stored.
// Depends on acs_pkg, acs_front, acs_queue and acs_back.
module alarm_clock_set_controller
  import acs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       btn_plus,
  input  logic       btn_minus,
  input  logic       btn_set,
  input  logic       btn_snooze,
  input  logic       blink_phase,
  input  logic [4:0] clock_hours,
  input  logic [5:0] clock_minutes,
  input  logic [5:0] clock_seconds,
  input  logic       rtc_pm,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] digit_hours_tens,
  output logic [3:0] digit_hours_units,
  output logic [3:0] digit_minutes_tens,
  output logic [3:0] digit_minutes_units,
  output logic       colon_lit,
  output logic       alarm_indicator,
  output logic       pm_indicator,
  output logic       alarm_armed,
  output logic       time_write,
  output logic [4:0] write_hours,
  output logic [5:0] write_minutes,
  output logic       write_pm
);

  logic    q_full;
  logic    q_not_empty;
  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   head;
  result_t result;

  acs_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .btn_plus      (btn_plus),
    .btn_minus     (btn_minus),
    .btn_set       (btn_set),
    .btn_snooze    (btn_snooze),
    .blink_phase   (blink_phase),
    .clock_hours   (clock_hours),
    .clock_minutes (clock_minutes),
    .clock_seconds (clock_seconds),
    .rtc_pm        (rtc_pm),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  acs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  acs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_not_empty    (q_not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result         (result)
  );

  assign digit_hours_tens    = result.digit_hours_tens;
  assign digit_hours_units   = result.digit_hours_units;
  assign digit_minutes_tens  = result.digit_minutes_tens;
  assign digit_minutes_units = result.digit_minutes_units;
  assign colon_lit           = result.colon_lit;
  assign alarm_indicator     = result.alarm_indicator;
  assign pm_indicator        = result.pm_indicator;
  assign alarm_armed         = result.alarm_armed;
  assign time_write          = result.time_write;
  assign write_hours         = result.write_hours;
  assign write_minutes       = result.write_minutes;
  assign write_pm            = result.write_pm;

endmodule

### sv/acs_front.sv
`timescale 1ns / 1ps
// Front end: takes requests off the input channel and packs them for the queue.
// Depends on acs_pkg.
module acs_front
  import acs_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       btn_plus,
  input  logic       btn_minus,
  input  logic       btn_set,
  input  logic       btn_snooze,
  input  logic       blink_phase,
  input  logic [4:0] clock_hours,
  input  logic [5:0] clock_minutes,
  input  logic [5:0] clock_seconds,
  input  logic       rtc_pm,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item                     = '0;
    push_item.buttons[BTN_PLUS]   = btn_plus;
    push_item.buttons[BTN_MINUS]  = btn_minus;
    push_item.buttons[BTN_SET]    = btn_set;
    push_item.buttons[BTN_SNOOZE] = btn_snooze;
    push_item.blink               = blink_phase;
    push_item.hours               = clock_hours;
    push_item.minutes             = clock_minutes;
    push_item.sec_even            = ~clock_seconds[0];
    push_item.pm                  = rtc_pm;
  end

endmodule

### sv/acs_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between the front end and the back end.
// Depends on acs_pkg.
module acs_queue
  import acs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  localparam int Depth = 2;

  item_t                     mem [Depth];
  logic [$clog2(Depth)-1:0]  wr_ptr;
  logic [$clog2(Depth)-1:0]  rd_ptr;
  logic [$clog2(Depth+1)-1:0] count;

  assign full      = (count == ($clog2(Depth+1))'(Depth));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/acs_back.sv
`timescale 1ns / 1ps
// Back end: the mode state machine, time and alarm edit registers, digit split
// and the output register. Depends on acs_pkg.
module acs_back
  import acs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_write_en,
  input  logic    cfg_write_data,
  input  logic    q_not_empty,
  input  item_t   head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result
);

  typedef enum logic [1:0] {
    MODE_START, MODE_IDLE, MODE_SET_MIN, MODE_SET_HRS
  } mode_t;

  typedef enum logic [1:0] {
    ENTRY_NONE, ENTRY_TIME, ENTRY_ALARM
  } entry_t;

  typedef enum logic [1:0] {
    FIELD_NONE, FIELD_MIN, FIELD_HRS
  } field_t;

  logic       hour_format_24;
  mode_t      mode, mode_next;
  logic [3:0] pending, pending_next;
  entry_t     entry, entry_next;
  field_t     field, field_next;
  logic       editing_alarm, editing_alarm_next;
  logic       alarm_enabled, alarm_enabled_next;
  logic       pm_flag, pm_flag_next;
  logic [4:0] edit_hours, edit_hours_next;
  logic [5:0] edit_minutes, edit_minutes_next;
  logic [4:0] alarm_hours, alarm_hours_next;
  logic [5:0] alarm_minutes, alarm_minutes_next;
  logic       alarm_pm, alarm_pm_next;
  logic       write;
  logic       editing;
  logic [4:0] show_hours;
  logic [5:0] show_minutes;
  logic       show_pm;
  logic [2:0] hrs_tens;
  result_t    result_next;

  assign pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    pending_next       = pending | head.buttons;
    mode_next          = mode;
    entry_next         = entry;
    field_next         = field;
    editing_alarm_next = editing_alarm;
    alarm_enabled_next = alarm_enabled;
    pm_flag_next       = pm_flag;
    edit_hours_next    = edit_hours;
    edit_minutes_next  = edit_minutes;
    alarm_hours_next   = alarm_hours;
    alarm_minutes_next = alarm_minutes;
    alarm_pm_next      = alarm_pm;
    write              = 1'b0;

    unique case (mode)
      MODE_START: begin
        mode_next = MODE_IDLE;
      end
      MODE_IDLE: begin
        pm_flag_next = head.pm;
        priority if (pending_next[BTN_SET]) begin
          pending_next[BTN_SET] = 1'b0;
          edit_hours_next       = head.hours;
          edit_minutes_next     = head.minutes;
          entry_next            = ENTRY_TIME;
          mode_next             = MODE_SET_MIN;
        end else if (pending_next[BTN_PLUS] && pending_next[BTN_MINUS]) begin
          pending_next[BTN_PLUS]  = 1'b0;
          pending_next[BTN_MINUS] = 1'b0;
          edit_hours_next         = alarm_hours;
          edit_minutes_next       = alarm_minutes;
          pm_flag_next            = alarm_pm;
          entry_next              = ENTRY_ALARM;
          mode_next               = MODE_SET_MIN;
        end else if (pending_next[BTN_SNOOZE]) begin
          pending_next[BTN_SNOOZE] = 1'b0;
          alarm_enabled_next       = ~alarm_enabled;
        end
      end
      MODE_SET_MIN: begin
        // The step after an edit starts only enters the minutes field.
        priority if (entry != ENTRY_NONE) begin
          editing_alarm_next = (entry == ENTRY_ALARM);
          field_next         = FIELD_MIN;
          entry_next         = ENTRY_NONE;
        end else if (pending_next[BTN_PLUS]) begin
          pending_next[BTN_PLUS] = 1'b0;
          edit_minutes_next = (edit_minutes >= MIN_LAST) ? 6'd0 : edit_minutes + 6'd1;
        end else if (pending_next[BTN_MINUS]) begin
          pending_next[BTN_MINUS] = 1'b0;
          edit_minutes_next = (edit_minutes == 6'd0) ? MIN_LAST : edit_minutes - 6'd1;
        end else if (pending_next[BTN_SET]) begin
          pending_next[BTN_SET] = 1'b0;
          mode_next             = MODE_SET_HRS;
        end
      end
      MODE_SET_HRS: begin
        priority if (field == FIELD_MIN) begin
          field_next = FIELD_HRS;
        end else if (pending_next[BTN_PLUS]) begin
          pending_next[BTN_PLUS] = 1'b0;
          priority if (hour_format_24 && edit_hours >= HRS_LAST_24) begin
            edit_hours_next = 5'd0;
          end else if (!hour_format_24 && edit_hours >= HRS_LAST_12) begin
            edit_hours_next = HRS_FIRST_12;
          end else begin
            if (edit_hours == HRS_PM_EDGE) begin
              pm_flag_next = ~pm_flag;
            end
            edit_hours_next = edit_hours + 5'd1;
          end
        end else if (pending_next[BTN_MINUS]) begin
          pending_next[BTN_MINUS] = 1'b0;
          priority if (hour_format_24 && edit_hours == 5'd0) begin
            edit_hours_next = HRS_LAST_24;
          end else if (!hour_format_24 && edit_hours <= HRS_FIRST_12) begin
            edit_hours_next = HRS_LAST_12;
          end else begin
            if (edit_hours == HRS_LAST_12) begin
              pm_flag_next = ~pm_flag;
            end
            edit_hours_next = edit_hours - 5'd1;
          end
        end else if (pending_next[BTN_SET]) begin
          pending_next[BTN_SET] = 1'b0;
          if (editing_alarm) begin
            alarm_hours_next   = edit_hours;
            alarm_minutes_next = edit_minutes;
            alarm_pm_next      = pm_flag;
            editing_alarm_next = 1'b0;
            alarm_enabled_next = 1'b1;
          end else begin
            write = 1'b1;
          end
          field_next = FIELD_NONE;
          mode_next  = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // Display values come from the updated state of this step.
  always_comb begin
    editing      = (field_next == FIELD_MIN) || (field_next == FIELD_HRS);
    show_hours   = editing ? edit_hours_next : head.hours;
    show_minutes = editing ? edit_minutes_next : head.minutes;
    show_pm      = editing ? pm_flag_next : head.pm;
    hrs_tens     = tens_of({1'b0, show_hours});

    result_next = '0;
    if (field_next == FIELD_HRS && head.blink) begin
      result_next.digit_hours_tens  = DIGIT_BLANK;
      result_next.digit_hours_units = DIGIT_BLANK;
    end else begin
      // A leading zero on the hours is blanked.
      result_next.digit_hours_tens  = (hrs_tens != 3'd0) ? {1'b0, hrs_tens} : DIGIT_BLANK;
      result_next.digit_hours_units = units_of({1'b0, show_hours});
    end
    if (field_next == FIELD_MIN && head.blink) begin
      result_next.digit_minutes_tens  = DIGIT_BLANK;
      result_next.digit_minutes_units = DIGIT_BLANK;
    end else begin
      result_next.digit_minutes_tens  = {1'b0, tens_of(show_minutes)};
      result_next.digit_minutes_units = units_of(show_minutes);
    end
    result_next.colon_lit       = editing || head.sec_even;
    result_next.alarm_indicator = alarm_enabled_next || editing_alarm_next;
    result_next.pm_indicator    = show_pm;
    result_next.alarm_armed     = alarm_enabled_next;
    result_next.time_write      = write;
    result_next.write_hours     = write ? edit_hours_next : 5'd0;
    result_next.write_minutes   = write ? edit_minutes_next : 6'd0;
    result_next.write_pm        = write && pm_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_format_24 <= 1'b0;
      mode           <= MODE_START;
      pending        <= '0;
      entry          <= ENTRY_NONE;
      field          <= FIELD_NONE;
      editing_alarm  <= 1'b0;
      alarm_enabled  <= 1'b0;
      pm_flag        <= 1'b0;
      edit_hours     <= '0;
      edit_minutes   <= '0;
      alarm_hours    <= '0;
      alarm_minutes  <= '0;
      alarm_pm       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        hour_format_24 <= cfg_write_data;
      end
      if (pop) begin
        mode          <= mode_next;
        pending       <= pending_next;
        entry         <= entry_next;
        field         <= field_next;
        editing_alarm <= editing_alarm_next;
        alarm_enabled <= alarm_enabled_next;
        pm_flag       <= pm_flag_next;
        edit_hours    <= edit_hours_next;
        edit_minutes  <= edit_minutes_next;
        alarm_hours   <= alarm_hours_next;
        alarm_minutes <= alarm_minutes_next;
        alarm_pm      <= alarm_pm_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

### sv/acs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the alarm clock set controller, bound to the top level.
// Depends only on the top level's ports.
module acs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] digit_hours_tens,
  input logic [3:0] digit_minutes_units,
  input logic       colon_lit,
  input logic       alarm_indicator,
  input logic       alarm_armed,
  input logic       time_write,
  input logic [4:0] write_hours,
  input logic [5:0] write_minutes,
  input logic       write_pm
);

  // The write fields are zero unless the strobe is set.
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !time_write |-> write_hours == 5'd0 && write_minutes == 6'd0 && !write_pm)
    else $error("write fields set without time_write");

  a_alarm_ind: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_armed |-> alarm_indicator)
    else $error("alarm armed but indicator dark");

  // A blank minutes digit only happens while editing, when the colon is steady.
  a_blank_colon: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_minutes_units == 4'd10 |-> colon_lit)
    else $error("blanked minutes with colon off");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_hours_tens) && $stable(time_write))
    else $error("stalled result changed");

endmodule

bind alarm_clock_set_controller acs_checker u_acs_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .digit_hours_tens    (digit_hours_tens),
  .digit_minutes_units (digit_minutes_units),
  .colon_lit           (colon_lit),
  .alarm_indicator     (alarm_indicator),
  .alarm_armed         (alarm_armed),
  .time_write          (time_write),
  .write_hours         (write_hours),
  .write_minutes       (write_minutes),
  .write_pm            (write_pm)
);
